// ===== sv/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope generator.
// Holds the transfer payload structs, operation codes, register map and widths.
// No dependencies.
`default_nettype none

package adsr_pkg;

    // Field and datapath widths.
    localparam int FRAME_BITS      = 48;
    localparam int LEVEL_FRAC_BITS = 15;
    localparam int LEVEL_W         = 16;
    localparam int SR_W            = 18;
    localparam int MS_W            = 14;
    localparam int NOTE_W          = FRAME_BITS + 1;
    localparam int DIFF_W          = FRAME_BITS + 2;
    localparam int LEN_W           = 23;
    localparam int PROD_W          = LEVEL_W + LEN_W;
    localparam int SMP_QBITS       = LEVEL_FRAC_BITS + 2;
    localparam int MUL_STEPS       = LEVEL_W;
    localparam int CNT_W           = 5;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    // Fixed-point level constants.
    localparam int unsigned ONE_INT = 1 << LEVEL_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(ONE_INT);
    localparam logic [LEVEL_W-1:0] LEVEL_EPS = LEVEL_W'((ONE_INT + 500) / 1000);
    localparam logic [LEN_W-1:0]   MS_DIVISOR = LEN_W'(1000);

    // Operation codes.
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [2:0] REG_ATTACK_MS   = 3'd1;
    localparam logic [2:0] REG_DECAY_MS    = 3'd2;
    localparam logic [2:0] REG_SUSTAIN     = 3'd3;
    localparam logic [2:0] REG_RELEASE_MS  = 3'd4;

    // Reset values.
    localparam logic [SR_W-1:0]    SAMPLE_RATE_RST = SR_W'(44100);
    localparam logic [MS_W-1:0]    ATTACK_MS_RST   = MS_W'(10);
    localparam logic [MS_W-1:0]    DECAY_MS_RST    = MS_W'(100);
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST     = LEVEL_W'(16384);
    localparam logic [MS_W-1:0]    RELEASE_MS_RST  = MS_W'(200);
    localparam logic [LEVEL_W-1:0] HELD_RST        = LEVEL_W'(16384);
    localparam logic signed [NOTE_W-1:0] NOTE_START_RST   = NOTE_W'(-64'sd88200);
    localparam logic signed [NOTE_W-1:0] NOTE_RELEASE_RST = NOTE_W'(-64'sd44200);

    // Request and response payloads.
    typedef struct packed {
        logic [1:0]            op;
        logic [FRAME_BITS-1:0] frame;
    } req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               bad_frame;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/adsr_envelope_generator_core.sv =====
// Top level of the linear ADSR envelope generator with its APB register file.
// Uses a bit-serial shift-add multiplier and a restoring divider; needs adsr_pkg.
// Note start/release events are registered directly from the idle state; a sample request
// passes through setup and classification to the hand-over state, which waits for a free
// output register; a ramp adds 16 multiply steps, then 17 divide steps, one bit per cycle.
// Throughput: one event per cycle while req_ready is high; one request in flight at a time.
// Segment lengths are recomputed after reset and after each register write, and req_ready
// stays low until they are done. rst_n clears all control state.
`default_nettype none

module adsr_envelope_generator_core (
    input  wire                          clk,
    input  wire                          rst_n,
    // Item channels.
    input  wire                          req_valid,
    output logic                         req_ready,
    input  adsr_pkg::req_t               req,
    output logic                         rsp_valid,
    input  wire                          rsp_ready,
    output adsr_pkg::rsp_t               rsp,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [adsr_pkg::ADDR_W-1:0]  paddr,
    input  wire  [adsr_pkg::DATA_W-1:0]  pwdata,
    output logic [adsr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    import adsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CLASS,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        JOB_ATTACK,
        JOB_DECAY,
        JOB_RELEASE,
        JOB_LEN_A,
        JOB_LEN_D,
        JOB_LEN_R
    } job_t;

    // Configuration registers.
    logic [SR_W-1:0]    sample_rate_reg;
    logic [MS_W-1:0]    attack_ms_reg;
    logic [MS_W-1:0]    decay_ms_reg;
    logic [LEVEL_W-1:0] sustain_reg;
    logic [MS_W-1:0]    release_ms_reg;
    logic               cfg_wr;

    // Control state.
    state_t                     state_reg, state_next;
    logic                       dirty_reg, dirty_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    rsp_t                       rsp_reg, rsp_next;
    logic signed [NOTE_W-1:0]   note_start_reg, note_start_next;
    logic signed [NOTE_W-1:0]   note_release_reg, note_release_next;
    logic [LEVEL_W-1:0]         held_reg, held_next;

    // Datapath registers.
    logic [FRAME_BITS-1:0]      frame_reg, frame_next;
    logic signed [DIFF_W-1:0]   t_reg, t_next;
    logic signed [DIFF_W-1:0]   rd_reg, rd_next;
    logic                       held_mode_reg, held_mode_next;
    job_t                       job_reg, job_next;
    logic [LEVEL_W-1:0]         k_reg, k_next;
    logic [LEN_W-1:0]           x_reg, x_next;
    logic [PROD_W-1:0]          acc_reg, acc_next;
    logic [LEN_W-1:0]           rem_reg, rem_next;
    logic [LEN_W-1:0]           lo_reg, lo_next;
    logic [LEN_W-1:0]           q_reg, q_next;
    logic [LEN_W-1:0]           div_reg, div_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [LEN_W-1:0]           a_len_reg, a_len_next;
    logic [LEN_W-1:0]           d_len_reg, d_len_next;
    logic [LEN_W-1:0]           r_len_reg, r_len_next;
    logic [LEVEL_W-1:0]         res_level_reg, res_level_next;
    logic                       res_bad_reg, res_bad_next;

    // Combinational helpers.
    logic [LEVEL_W-1:0]         sustain_clamp;
    logic signed [DIFF_W-1:0]   u_diff;
    logic                       rel_zero;
    logic [LEN_W-1:0]           rel_dist;
    logic [LEN_W:0]             trial;
    logic [LEN_W:0]             div_ext;
    logic                       len_job;
    logic [CNT_W-1:0]           div_last;
    logic [LEVEL_W-1:0]         lv;

    // Configuration port: writes complete in the access phase, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RST;
            attack_ms_reg   <= ATTACK_MS_RST;
            decay_ms_reg    <= DECAY_MS_RST;
            sustain_reg     <= SUSTAIN_RST;
            release_ms_reg  <= RELEASE_MS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[ADDR_W-1:2])
                REG_SAMPLE_RATE: sample_rate_reg <= pwdata[SR_W-1:0];
                REG_ATTACK_MS:   attack_ms_reg   <= pwdata[MS_W-1:0];
                REG_DECAY_MS:    decay_ms_reg    <= pwdata[MS_W-1:0];
                REG_SUSTAIN:     sustain_reg     <= pwdata[LEVEL_W-1:0];
                REG_RELEASE_MS:  release_ms_reg  <= pwdata[MS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_SAMPLE_RATE: prdata = DATA_W'(sample_rate_reg);
            REG_ATTACK_MS:   prdata = DATA_W'(attack_ms_reg);
            REG_DECAY_MS:    prdata = DATA_W'(decay_ms_reg);
            REG_SUSTAIN:     prdata = DATA_W'(sustain_reg);
            REG_RELEASE_MS:  prdata = DATA_W'(release_ms_reg);
            default:         prdata = '0;
        endcase
    end

    // Segment classification helpers.
    assign sustain_clamp = (sustain_reg > LEVEL_ONE) ? LEVEL_ONE : sustain_reg;
    assign u_diff = t_reg - $signed({{(DIFF_W-LEN_W){1'b0}}, a_len_reg});
    assign rel_zero = (r_len_reg == '0) ||
                      (!rd_reg[DIFF_W-1] &&
                       (rd_reg >= $signed({{(DIFF_W-LEN_W){1'b0}}, r_len_reg})));
    assign rel_dist = rd_reg[DIFF_W-1] ? '0 : rd_reg[LEN_W-1:0];

    // One restoring division step.
    assign div_ext  = {1'b0, div_reg};
    assign trial    = {rem_reg, lo_reg[LEN_W-1]};
    assign len_job  = (job_reg == JOB_LEN_A) || (job_reg == JOB_LEN_D) ||
                      (job_reg == JOB_LEN_R);
    assign div_last = len_job ? CNT_W'(LEN_W - 1) : CNT_W'(SMP_QBITS - 1);

    assign req_ready = (state_reg == ST_IDLE) && !dirty_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        dirty_next        = dirty_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_next          = rsp_reg;
        note_start_next   = note_start_reg;
        note_release_next = note_release_reg;
        held_next         = held_reg;
        frame_next        = frame_reg;
        t_next            = t_reg;
        rd_next           = rd_reg;
        held_mode_next    = held_mode_reg;
        job_next          = job_reg;
        k_next            = k_reg;
        x_next            = x_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        lo_next           = lo_reg;
        q_next            = q_reg;
        div_next          = div_reg;
        cnt_next          = cnt_reg;
        a_len_next        = a_len_reg;
        d_len_next        = d_len_reg;
        r_len_next        = r_len_reg;
        res_level_next    = res_level_reg;
        res_bad_next      = res_bad_reg;
        lv                = q_reg[LEVEL_W-1:0];

        // The output register empties on a completed transfer.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    // Recompute the attack length first, then decay and release.
                    dirty_next = 1'b0;
                    job_next   = JOB_LEN_A;
                    k_next     = LEVEL_W'(attack_ms_reg);
                    x_next     = LEN_W'(sample_rate_reg);
                    div_next   = MS_DIVISOR;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else if (req_valid)
                begin
                    case (req.op)
                        OP_SAMPLE:
                        begin
                            frame_next = req.frame;
                            state_next = ST_SETUP;
                        end
                        OP_START:   note_start_next   = $signed({1'b0, req.frame});
                        OP_RELEASE: note_release_next = $signed({1'b0, req.frame});
                        default:    ;
                    endcase
                end
            end

            ST_SETUP:
            begin
                // Distances from the start and release events, and the note mode.
                t_next = $signed({2'b00, frame_reg}) -
                         $signed({note_start_reg[NOTE_W-1], note_start_reg});
                rd_next = $signed({2'b00, frame_reg}) -
                          $signed({note_release_reg[NOTE_W-1], note_release_reg});
                held_mode_next = (note_start_reg >= note_release_reg);
                state_next = ST_CLASS;
            end

            ST_CLASS:
            begin
                acc_next     = '0;
                cnt_next     = '0;
                res_bad_next = 1'b0;
                if (t_reg[DIFF_W-1])
                begin
                    // Frame before the note start.
                    res_level_next = '0;
                    res_bad_next   = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (held_mode_reg)
                begin
                    if (u_diff > $signed({{(DIFF_W-LEN_W){1'b0}}, d_len_reg}))
                    begin
                        // Sustain plateau.
                        res_level_next = sustain_clamp;
                        held_next      = sustain_clamp;
                        state_next     = ST_DONE;
                    end
                    else if (!u_diff[DIFF_W-1] && (u_diff != '0))
                    begin
                        job_next   = JOB_DECAY;
                        k_next     = LEVEL_ONE - sustain_clamp;
                        x_next     = u_diff[LEN_W-1:0];
                        div_next   = d_len_reg;
                        state_next = ST_MUL;
                    end
                    else if (a_len_reg == '0)
                    begin
                        // A zero-length attack starts at full level.
                        res_level_next = LEVEL_ONE;
                        held_next      = LEVEL_ONE;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        job_next   = JOB_ATTACK;
                        k_next     = LEVEL_ONE - LEVEL_EPS;
                        x_next     = t_reg[LEN_W-1:0];
                        div_next   = a_len_reg;
                        state_next = ST_MUL;
                    end
                end
                else if (rel_zero)
                begin
                    // Release finished, or a zero-length release.
                    res_level_next = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    job_next   = JOB_RELEASE;
                    k_next     = held_reg;
                    x_next     = r_len_reg - rel_dist;
                    div_next   = r_len_reg;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // Shift-add multiply, multiplier bits taken most significant first.
                acc_next = {acc_reg[PROD_W-2:0], 1'b0} +
                           (k_reg[LEVEL_W-1] ? PROD_W'(x_reg) : '0);
                k_next   = {k_reg[LEVEL_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_DIV_LOAD;
                end
            end

            ST_DIV_LOAD:
            begin
                // The quotient bound fixes how many dividend bits enter the remainder.
                if (len_job)
                begin
                    rem_next = LEN_W'(acc_reg[PROD_W-1:LEN_W]);
                    lo_next  = acc_reg[LEN_W-1:0];
                end
                else
                begin
                    rem_next = LEN_W'(acc_reg[PROD_W-1:SMP_QBITS]);
                    lo_next  = {acc_reg[SMP_QBITS-1:0], {(LEN_W-SMP_QBITS){1'b0}}};
                end
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (trial >= div_ext)
                begin
                    rem_next = LEN_W'(trial - div_ext);
                    q_next   = {q_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[LEN_W-1:0];
                    q_next   = {q_reg[LEN_W-2:0], 1'b0};
                end
                lo_next  = {lo_reg[LEN_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == div_last)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                acc_next = '0;
                cnt_next = '0;
                case (job_reg)
                    JOB_LEN_A:
                    begin
                        a_len_next = q_reg;
                        job_next   = JOB_LEN_D;
                        k_next     = LEVEL_W'(decay_ms_reg);
                        x_next     = LEN_W'(sample_rate_reg);
                        state_next = ST_MUL;
                    end
                    JOB_LEN_D:
                    begin
                        d_len_next = q_reg;
                        job_next   = JOB_LEN_R;
                        k_next     = LEVEL_W'(release_ms_reg);
                        x_next     = LEN_W'(sample_rate_reg);
                        state_next = ST_MUL;
                    end
                    JOB_LEN_R:
                    begin
                        r_len_next = q_reg;
                        state_next = ST_IDLE;
                    end
                    JOB_ATTACK:
                    begin
                        lv             = LEVEL_EPS + q_reg[LEVEL_W-1:0];
                        res_level_next = lv;
                        held_next      = lv;
                        state_next     = ST_DONE;
                    end
                    JOB_DECAY:
                    begin
                        lv             = LEVEL_ONE - q_reg[LEVEL_W-1:0];
                        res_level_next = lv;
                        held_next      = lv;
                        state_next     = ST_DONE;
                    end
                    JOB_RELEASE:
                    begin
                        res_level_next = lv;
                        state_next     = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.level     = res_level_reg;
                    rsp_next.bad_frame = res_bad_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any register write forces the segment lengths to be recomputed.
        if (cfg_wr)
        begin
            dirty_next = 1'b1;
        end
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dirty_reg        <= 1'b1;
            rsp_valid_reg    <= 1'b0;
            rsp_reg          <= '0;
            note_start_reg   <= NOTE_START_RST;
            note_release_reg <= NOTE_RELEASE_RST;
            held_reg         <= HELD_RST;
        end
        else
        begin
            state_reg        <= state_next;
            dirty_reg        <= dirty_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_reg          <= rsp_next;
            note_start_reg   <= note_start_next;
            note_release_reg <= note_release_next;
            held_reg         <= held_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        t_reg         <= t_next;
        rd_reg        <= rd_next;
        held_mode_reg <= held_mode_next;
        job_reg       <= job_next;
        k_reg         <= k_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        lo_reg        <= lo_next;
        q_reg         <= q_next;
        div_reg       <= div_next;
        cnt_reg       <= cnt_next;
        a_len_reg     <= a_len_next;
        d_len_reg     <= d_len_next;
        r_len_reg     <= r_len_next;
        res_level_reg <= res_level_next;
        res_bad_reg   <= res_bad_next;
    end

    // The divider never starts with a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_LOAD) |-> (div_reg != '0))
        else $error("divider started with a zero divisor");

    // A ramp quotient never exceeds full level.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) &&
         ((job_reg == JOB_ATTACK) || (job_reg == JOB_DECAY) ||
          (job_reg == JOB_RELEASE)))
        |-> (q_reg <= LEN_W'(LEVEL_ONE)))
        else $error("ramp quotient above full level");

    // The remembered level never exceeds full level (1.0 in Q1.15).
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= LEVEL_ONE)
        else $error("held level above full level");

    // A response appears only from the hand-over state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("response raised outside the hand-over state");

endmodule

`default_nettype wire
